// File: src/circle_pair_intersection_top_defines.svh
// ----------------------------------------------------------------------------
// circle pair intersection assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_INTERSECTION_TOP_DEFINES_SVH
`define CIRCLE_PAIR_INTERSECTION_TOP_DEFINES_SVH

// checked only out of reset
`define CPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CPI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/cpi_pkg.sv
// ----------------------------------------------------------------------------
// cpi_pkg
// widths, cell types and helpers of the circle pair intersection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package cpi_pkg;

  localparam int COORD_W    = 32;
  localparam int RAD_W      = COORD_W - 1;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQR_W      = 2 * DIFF_W;
  localparam int RSQ_W      = 2 * RAD_W;
  localparam int ROOT_W     = DIFF_W;
  localparam int SQ_REM_W   = ROOT_W + 3;
  localparam int SQ_STEPS   = ROOT_W;
  localparam int DIV_Q_W    = RAD_W;
  localparam int DIV_DEN_W  = ROOT_W + 1;
  localparam int DIV_STEPS  = DIV_Q_W;
  localparam int PROD_W     = RAD_W + DIFF_W;
  localparam int TOL_W      = 16;
  localparam int SUM_W      = COORD_W + 3;
  localparam int IN_RAW_W   = 4 * COORD_W + 2 * RAD_W;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 4 * COORD_W;
  localparam int LATENCY    = 3 + SQ_STEPS + 3 + DIV_STEPS + 2 + SQ_STEPS + 1 + DIV_STEPS + 1;

  localparam int X1_LSB = 0;
  localparam int Y1_LSB = COORD_W;
  localparam int R1_LSB = 2 * COORD_W;
  localparam int X2_LSB = 2 * COORD_W + RAD_W;
  localparam int Y2_LSB = 3 * COORD_W + RAD_W;
  localparam int R2_LSB = 4 * COORD_W + RAD_W;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  typedef struct packed {
    logic [SQR_W-1:0]    rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_Q_W-1:0]   low;
    logic [DIV_Q_W-1:0]   quo;
  } dv_t;

  // numerator must satisfy num < den * 2^DIV_Q_W
  function automatic dv_t dv_init(logic [SQR_W-1:0] num, logic [DIV_DEN_W-1:0] den);
    dv_t r;
    r.den = den;
    r.rem = num[DIV_Q_W +: DIV_DEN_W];
    r.low = num[DIV_Q_W-1:0];
    r.quo = '0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/cpi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// cpi_sqrt_cell
// one digit step of the integer square root, registered
// ----------------------------------------------------------------------------
`default_nettype none

module cpi_sqrt_cell import cpi_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  sq_t  sq_i,
  output sq_t  sq_o
);

  logic [SQ_REM_W-1:0] rem_s;
  logic [SQ_REM_W-1:0] trial;
  logic [SQ_REM_W-1:0] diff;
  sq_t                 sq_d;
  sq_t                 sq_q;

  always_comb begin
    rem_s = {sq_i.rem[SQ_REM_W-3:0], sq_i.rad[SQR_W-1 -: 2]};
    trial = {{(SQ_REM_W-ROOT_W-2){1'b0}}, sq_i.root, 2'b01};
    diff  = rem_s - trial;
    sq_d.rad = {sq_i.rad[SQR_W-3:0], 2'b00};
    if (rem_s >= trial) begin
      sq_d.rem  = diff;
      sq_d.root = {sq_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_d.rem  = rem_s;
      sq_d.root = {sq_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// File: src/cpi_div_cell.sv
// ----------------------------------------------------------------------------
// cpi_div_cell
// one restoring division step, registered
// ----------------------------------------------------------------------------
`default_nettype none

module cpi_div_cell import cpi_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  dv_t  dv_i,
  output dv_t  dv_o
);

  logic [DIV_DEN_W:0] sh;
  logic [DIV_DEN_W:0] diff;
  dv_t                dv_d;
  dv_t                dv_q;

  always_comb begin
    sh       = {dv_i.rem, dv_i.low[DIV_Q_W-1]};
    diff     = sh - {1'b0, dv_i.den};
    dv_d.den = dv_i.den;
    dv_d.low = {dv_i.low[DIV_Q_W-2:0], 1'b0};
    if (!diff[DIV_DEN_W]) begin
      dv_d.rem = diff[DIV_DEN_W-1:0];
      dv_d.quo = {dv_i.quo[DIV_Q_W-2:0], 1'b1};
    end else begin
      dv_d.rem = sh[DIV_DEN_W-1:0];
      dv_d.quo = {dv_i.quo[DIV_Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule

`default_nettype wire

// File: src/circle_pair_intersection_top.sv
// ----------------------------------------------------------------------------
// circle_pair_intersection_top
// pipeline: from input request to result through the two root rows
// (33 cells each), two divider rows in sequence (31 cells each, the second four wide) and 10 glue stages
// throughput: one circle pair per cycle; the whole pipeline holds while the
// result register waits
// reset: clears all valid bits and sets tolerance to 1, data is not reset
// ----------------------------------------------------------------------------
`default_nettype none

module circle_pair_intersection_top import cpi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // x1, y1, r1, x2, y2, r2, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // p1x, p1y, p2x, p2y
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // found
  output logic                  m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [TOL_W-1:0]      cfg_data_i
);

  localparam int CHK_W  = ROOT_W + 2;
  localparam int OFF_N  = 4;
  localparam int IDX_AX = 0;
  localparam int IDX_AY = 1;
  localparam int IDX_HY = 2;
  localparam int IDX_HX = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [RAD_W-1:0]          r1;
    logic [RAD_W-1:0]          r2;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
  } a_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [RAD_W-1:0]          r1;
    logic [RAD_W-1:0]          r2;
    logic                      dx_neg;
    logic                      dy_neg;
    logic [DIFF_W-1:0]         dxm;
    logic [DIFF_W-1:0]         dym;
    logic [SQR_W-1:0]          dx2;
    logic [SQR_W-1:0]          dy2;
    logic [RSQ_W-1:0]          r1s;
    logic [RSQ_W-1:0]          r2s;
  } b_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [RAD_W-1:0]          r1;
    logic [RAD_W-1:0]          r2;
    logic                      dx_neg;
    logic                      dy_neg;
    logic [DIFF_W-1:0]         dxm;
    logic [DIFF_W-1:0]         dym;
    logic [RSQ_W-1:0]          r1s;
    logic [RSQ_W-1:0]          r2s;
    logic [SQR_W-1:0]          d2;
  } s1_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [RAD_W-1:0]          r1;
    logic [RSQ_W-1:0]          r1s;
    logic                      dx_neg;
    logic                      dy_neg;
    logic [DIFF_W-1:0]         dxm;
    logic [DIFF_W-1:0]         dym;
    logic [ROOT_W-1:0]         d;
    logic                      found;
    logic                      a_neg;
  } s2_t;

  typedef struct packed {
    s2_t              side;
    logic [SQR_W-1:0] p;
    logic [RSQ_W-1:0] q;
  } d_t;

  typedef struct packed {
    s2_t              side;
    logic [SQR_W-1:0] num;
  } e_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic                      dx_neg;
    logic                      dy_neg;
    logic [DIFF_W-1:0]         dxm;
    logic [DIFF_W-1:0]         dym;
    logic [ROOT_W-1:0]         d;
    logic                      found;
    logic                      a_neg;
    logic [DIV_Q_W-1:0]        am;
  } s3_t;

  typedef struct packed {
    s3_t              side;
    logic [RSQ_W-1:0] r1s;
    logic [RSQ_W-1:0] a2;
  } g_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic                      found;
    logic [OFF_N-1:0]          neg;
  } s4_t;

  function automatic logic signed [SUM_W-1:0] off_f(logic neg, logic [DIV_Q_W-1:0] q);
    logic signed [SUM_W-1:0] v;
    v = $signed({{(SUM_W-DIV_Q_W){1'b0}}, q});
    return neg ? -v : v;
  endfunction

  function automatic logic [COORD_W-1:0] sat_f(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = $signed({{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    lo = $signed({{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});
    if (v > hi) begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end
    return v[COORD_W-1:0];
  endfunction

  logic                en;
  logic                acc;
  logic [LATENCY-1:0]  vld_q;
  logic [TOL_W-1:0]    tol_q;

  a_t  a_d, a_q;
  b_t  b_d, b_q;
  s1_t c_d, c_q;
  s1_t sd1_q [SQ_STEPS];
  d_t  d_d, d_q;
  e_t  e_d, e_q;
  s2_t f_side_d;
  s2_t f_side_q;
  logic [SQR_W-1:0]     f_num_q;
  logic [DIV_DEN_W-1:0] f_den_q;
  logic                 f_found;
  s2_t sd2_q [DIV_STEPS];
  g_t  g_d, g_q;
  s3_t h_side_q;
  logic [SQR_W-1:0]     h_rad_q;
  s3_t sd3_q [SQ_STEPS];
  s4_t p_side_d, p_side_q;
  logic [PROD_W-1:0]    p_prod_d [OFF_N];
  logic [PROD_W-1:0]    p_prod_q [OFF_N];
  logic [ROOT_W-1:0]    p_d_q;
  s4_t sd4_q [DIV_STEPS];
  logic [OUT_DATA_W-1:0] out_d, out_q;
  logic                  found_q;

  sq_t sq1 [SQ_STEPS+1];
  sq_t sq2 [SQ_STEPS+1];
  dv_t dv1 [DIV_STEPS+1];
  dv_t dvo [OFF_N][DIV_STEPS+1];

  // handshake
  assign en            = !vld_q[LATENCY-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LATENCY-2:0], acc};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // center differences
  always_comb begin
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
    x2     = s_axis_tdata[X2_LSB +: COORD_W];
    y2     = s_axis_tdata[Y2_LSB +: COORD_W];
    a_d.x1 = s_axis_tdata[X1_LSB +: COORD_W];
    a_d.y1 = s_axis_tdata[Y1_LSB +: COORD_W];
    a_d.r1 = s_axis_tdata[R1_LSB +: RAD_W];
    a_d.r2 = s_axis_tdata[R2_LSB +: RAD_W];
    a_d.dx = $signed({x2[COORD_W-1], x2}) - $signed({a_d.x1[COORD_W-1], a_d.x1});
    a_d.dy = $signed({y2[COORD_W-1], y2}) - $signed({a_d.y1[COORD_W-1], a_d.y1});
  end

  // squares
  always_comb begin
    logic signed [SQR_W-1:0] dx2s;
    logic signed [SQR_W-1:0] dy2s;
    dx2s = SQR_W'(a_q.dx) * SQR_W'(a_q.dx);
    dy2s = SQR_W'(a_q.dy) * SQR_W'(a_q.dy);
    b_d.x1     = a_q.x1;
    b_d.y1     = a_q.y1;
    b_d.r1     = a_q.r1;
    b_d.r2     = a_q.r2;
    b_d.dx_neg = a_q.dx[DIFF_W-1];
    b_d.dy_neg = a_q.dy[DIFF_W-1];
    b_d.dxm    = a_q.dx[DIFF_W-1] ? DIFF_W'(-a_q.dx) : a_q.dx;
    b_d.dym    = a_q.dy[DIFF_W-1] ? DIFF_W'(-a_q.dy) : a_q.dy;
    b_d.dx2    = dx2s;
    b_d.dy2    = dy2s;
    b_d.r1s    = RSQ_W'(a_q.r1) * RSQ_W'(a_q.r1);
    b_d.r2s    = RSQ_W'(a_q.r2) * RSQ_W'(a_q.r2);
  end

  always_comb begin
    c_d.x1     = b_q.x1;
    c_d.y1     = b_q.y1;
    c_d.r1     = b_q.r1;
    c_d.r2     = b_q.r2;
    c_d.dx_neg = b_q.dx_neg;
    c_d.dy_neg = b_q.dy_neg;
    c_d.dxm    = b_q.dxm;
    c_d.dym    = b_q.dym;
    c_d.r1s    = b_q.r1s;
    c_d.r2s    = b_q.r2s;
    c_d.d2     = b_q.dx2 + b_q.dy2;
  end

  // center distance root row
  always_comb begin
    sq1[0].rad  = c_q.d2;
    sq1[0].rem  = '0;
    sq1[0].root = '0;
  end

  // degenerate checks
  always_comb begin
    s1_t                     s;
    logic [ROOT_W-1:0]       dd;
    logic signed [CHK_W-1:0] de;
    logic signed [CHK_W-1:0] touch;
    logic signed [CHK_W-1:0] touch_abs;
    logic [RAD_W-1:0]        rdiff;
    logic signed [CHK_W-1:0] dmr;
    logic signed [CHK_W-1:0] tolx;
    s         = sd1_q[SQ_STEPS-1];
    dd        = sq1[SQ_STEPS].root;
    de        = $signed({2'b00, dd});
    touch     = de - $signed({4'b0000, s.r1}) - $signed({4'b0000, s.r2});
    touch_abs = touch[CHK_W-1] ? -touch : touch;
    rdiff     = (s.r1 > s.r2) ? s.r1 - s.r2 : s.r2 - s.r1;
    dmr       = de - $signed({4'b0000, rdiff});
    tolx      = $signed({{(CHK_W-TOL_W){1'b0}}, tol_q});
    d_d.side.x1     = s.x1;
    d_d.side.y1     = s.y1;
    d_d.side.r1     = s.r1;
    d_d.side.r1s    = s.r1s;
    d_d.side.dx_neg = s.dx_neg;
    d_d.side.dy_neg = s.dy_neg;
    d_d.side.dxm    = s.dxm;
    d_d.side.dym    = s.dym;
    d_d.side.d      = dd;
    d_d.side.found  = (de > tolx) && (touch_abs > tolx) && (dmr > tolx);
    d_d.side.a_neg  = 1'b0;
    d_d.p           = s.d2 + {{(SQR_W-RSQ_W){1'b0}}, s.r1s};
    d_d.q           = s.r2s;
  end

  // foot point numerator
  always_comb begin
    logic [SQR_W-1:0] qx;
    qx               = {{(SQR_W-RSQ_W){1'b0}}, d_q.q};
    e_d.side         = d_q.side;
    e_d.side.a_neg   = qx > d_q.p;
    e_d.num          = (qx > d_q.p) ? qx - d_q.p : d_q.p - qx;
  end

  assign f_found = e_q.side.found &&
                   (e_q.num < {1'b0, e_q.side.d, 1'b0, {DIV_Q_W{1'b0}}});

  always_comb begin
    f_side_d       = e_q.side;
    f_side_d.found = f_found;
  end

  // foot distance divider row
  assign dv1[0] = dv_init(f_num_q, f_den_q);

  always_comb begin
    s2_t s;
    s                = sd2_q[DIV_STEPS-1];
    g_d.side.x1      = s.x1;
    g_d.side.y1      = s.y1;
    g_d.side.dx_neg  = s.dx_neg;
    g_d.side.dy_neg  = s.dy_neg;
    g_d.side.dxm     = s.dxm;
    g_d.side.dym     = s.dym;
    g_d.side.d       = s.d;
    g_d.side.found   = s.found && (dv1[DIV_STEPS].quo <= s.r1);
    g_d.side.a_neg   = s.a_neg;
    g_d.side.am      = dv1[DIV_STEPS].quo;
    g_d.r1s          = s.r1s;
    g_d.a2           = RSQ_W'(dv1[DIV_STEPS].quo) * RSQ_W'(dv1[DIV_STEPS].quo);
  end

  // half chord root row
  always_comb begin
    sq2[0].rad  = h_rad_q;
    sq2[0].rem  = '0;
    sq2[0].root = '0;
  end

  // offset products
  always_comb begin
    s3_t              s;
    logic [RAD_W-1:0] h;
    s = sd3_q[SQ_STEPS-1];
    h = sq2[SQ_STEPS].root[RAD_W-1:0];
    p_prod_d[IDX_AX] = PROD_W'(s.am) * PROD_W'(s.dxm);
    p_prod_d[IDX_AY] = PROD_W'(s.am) * PROD_W'(s.dym);
    p_prod_d[IDX_HY] = PROD_W'(h) * PROD_W'(s.dxm);
    p_prod_d[IDX_HX] = PROD_W'(h) * PROD_W'(s.dym);
    p_side_d.x1          = s.x1;
    p_side_d.y1          = s.y1;
    p_side_d.found       = s.found;
    p_side_d.neg[IDX_AX] = s.a_neg ^ s.dx_neg;
    p_side_d.neg[IDX_AY] = s.a_neg ^ s.dy_neg;
    p_side_d.neg[IDX_HY] = s.dx_neg;
    p_side_d.neg[IDX_HX] = s.dy_neg;
  end

  // crossing points
  always_comb begin
    s4_t                     s;
    logic signed [SUM_W-1:0] ox, oy, hx, hy, bx, by;
    s  = sd4_q[DIV_STEPS-1];
    ox = off_f(s.neg[IDX_AX], dvo[IDX_AX][DIV_STEPS].quo);
    oy = off_f(s.neg[IDX_AY], dvo[IDX_AY][DIV_STEPS].quo);
    hx = off_f(s.neg[IDX_HX], dvo[IDX_HX][DIV_STEPS].quo);
    hy = off_f(s.neg[IDX_HY], dvo[IDX_HY][DIV_STEPS].quo);
    bx = $signed({{(SUM_W-COORD_W){s.x1[COORD_W-1]}}, s.x1}) + ox;
    by = $signed({{(SUM_W-COORD_W){s.y1[COORD_W-1]}}, s.y1}) + oy;
    if (s.found) begin
      out_d = {sat_f(by + hy), sat_f(bx - hx), sat_f(by - hy), sat_f(bx + hx)};
    end else begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q      <= a_d;
      b_q      <= b_d;
      c_q      <= c_d;
      d_q      <= d_d;
      e_q      <= e_d;
      f_side_q <= f_side_d;
      f_num_q  <= e_q.num;
      f_den_q  <= {e_q.side.d, 1'b0};
      g_q      <= g_d;
      h_side_q <= g_q.side;
      h_rad_q  <= {{(SQR_W-RSQ_W){1'b0}}, g_q.r1s - g_q.a2};
      p_side_q <= p_side_d;
      p_prod_q <= p_prod_d;
      p_d_q    <= sd3_q[SQ_STEPS-1].d;
      out_q    <= out_d;
      found_q  <= sd4_q[DIV_STEPS-1].found;
      sd1_q[0] <= c_q;
      sd2_q[0] <= f_side_q;
      sd3_q[0] <= h_side_q;
      sd4_q[0] <= p_side_q;
      for (int i = 1; i < SQ_STEPS; i++) begin
        sd1_q[i] <= sd1_q[i-1];
        sd3_q[i] <= sd3_q[i-1];
      end
      for (int i = 1; i < DIV_STEPS; i++) begin
        sd2_q[i] <= sd2_q[i-1];
        sd4_q[i] <= sd4_q[i-1];
      end
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    cpi_sqrt_cell u_sq1 (.clk_i(clk_i), .en_i(en), .sq_i(sq1[i]), .sq_o(sq1[i+1]));
    cpi_sqrt_cell u_sq2 (.clk_i(clk_i), .en_i(en), .sq_i(sq2[i]), .sq_o(sq2[i+1]));
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv1
    cpi_div_cell u_dv (.clk_i(clk_i), .en_i(en), .dv_i(dv1[i]), .dv_o(dv1[i+1]));
  end

  for (genvar k = 0; k < OFF_N; k++) begin : g_off
    assign dvo[k][0] = dv_init({{(SQR_W-PROD_W){1'b0}}, p_prod_q[k]}, {1'b0, p_d_q});
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      cpi_div_cell u_dv (.clk_i(clk_i), .en_i(en), .dv_i(dvo[k][i]), .dv_o(dvo[k][i+1]));
    end
  end

  assign m_axis_tvalid = vld_q[LATENCY-1];
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = found_q;

endmodule

`default_nettype wire

// File: src/cpi_checker.sv
// ----------------------------------------------------------------------------
// cpi_checker
// port level checks of the circle pair intersection block
// ----------------------------------------------------------------------------
`default_nettype none
`include "circle_pair_intersection_top_defines.svh"

module cpi_checker import cpi_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  cfg_ready_o
);

  `CPI_ASSERT(a_zero_points, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "points not zero")
  `CPI_ASSERT(a_hold_result, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `CPI_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready && cfg_ready_o, "input blocked")
  `CPI_ASSERT_RST(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "result shown in reset")

endmodule

bind circle_pair_intersection_top cpi_checker u_cpi_checker (.*);

`default_nettype wire
